[design/ars_pkg.sv]
// ride statistics package: shared constants, controller states and the
// command/status structs between the controller and the datapath
// no dependencies
`timescale 1ns / 1ps

package ars_pkg;

   // default field widths
   localparam int SAMPLE_BITS_DEF = 13;
   localparam int COUNT_BITS_DEF  = 16;

   // transaction kinds on the request channel
   localparam logic [1:0] KIND_SAMPLE = 2'd0;
   localparam logic [1:0] KIND_START  = 2'd1;
   localparam logic [1:0] KIND_FINISH = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_SUM,
      ST_ROOT,
      ST_UPDATE,
      ST_DIVIDE,
      ST_COMMIT
   } state_type;

   typedef struct packed {
      logic capture;     // latch axis magnitudes of the request
      logic clear;       // open a ride: clear the statistics
      logic square;      // register the three squares
      logic load_root;   // load radicand, reset root and remainder
      logic root_step;   // one digit of the square root
      logic update;      // fold the new magnitude into the statistics
      logic load_div;    // load total and count into the divider
      logic div_step;    // one quotient bit
      logic load_rsp;    // load the response register
      logic summary;     // response is a ride summary
   } cmd_type;

   typedef struct packed {
      logic count_zero;  // no sample counted in this ride
   } status_type;

endpackage

[design/ars_ctrl.sv]
// ride statistics controller: sequences one transaction through square,
// root, update and divide steps and owns the ride and response valid bits
// depends on ars_pkg
`timescale 1ns / 1ps

module ars_ctrl import ars_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_kind,
   input  logic       req_during_vibration,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam int STEP_W = $clog2(SAMPLE_BITS);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              ride_ff, ride_in;
   logic              summary_ff, summary_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              last_step;
   logic              accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign last_step = (step_ff == STEP_W'(SAMPLE_BITS - 1));
   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         ride_ff      <= 1'b0;
         summary_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         ride_ff      <= ride_in;
         summary_ff   <= summary_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      ride_in      = ride_ff;
      summary_in   = summary_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               summary_in  = 1'b0;
               state_in    = ST_COMMIT;
               case (req_kind)
                  KIND_SAMPLE: begin
                     if (ride_ff && !req_during_vibration) begin
                        state_in = ST_SQUARE;
                     end
                  end
                  KIND_START: begin
                     if (!ride_ff) begin
                        cmd.clear = 1'b1;
                        ride_in   = 1'b1;
                     end
                  end
                  KIND_FINISH: begin
                     ride_in    = 1'b0;
                     summary_in = 1'b1;
                     if (!status.count_zero) begin
                        cmd.load_div = 1'b1;
                        step_in      = '0;
                        state_in     = ST_DIVIDE;
                     end
                  end
                  default: begin
                     state_in = ST_COMMIT;
                  end
               endcase
            end
         end
         ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.load_root = 1'b1;
            step_in       = '0;
            state_in      = ST_ROOT;
         end
         ST_ROOT: begin
            cmd.root_step = 1'b1;
            step_in       = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_COMMIT;
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (last_step) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            cmd.summary = summary_ff;
            if (!(rsp_valid_ff && rsp_stall)) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

[design/ars_datapath.sv]
// ride statistics datapath: axis magnitudes, squares, digit-serial square
// root, restoring divider, ride statistics and the response register
// depends on ars_pkg
`timescale 1ns / 1ps

module ars_datapath import ars_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cmd_type                       cmd,
   output status_type                    status,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   output logic [SAMPLE_BITS-1:0]        rsp_current_magnitude,
   output logic [COUNT_BITS-1:0]         rsp_count_of_samples,
   output logic [SAMPLE_BITS-1:0]        rsp_highest_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_lowest_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_mean_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_x,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_y,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_z,
   output logic                          rsp_is_summary
);

   localparam int S  = SAMPLE_BITS;
   localparam int C  = COUNT_BITS;
   localparam int SW = S + C;

   // axis magnitudes and squares
   logic [S-1:0]   abs_x_ff, abs_y_ff, abs_z_ff;
   logic [2*S-1:0] sq_x_ff, sq_y_ff, sq_z_ff;

   // square root
   logic [2*S-1:0] rad_ff;
   logic [S+1:0]   rem_ff, rem_t, trial;
   logic [S-1:0]   root_ff;
   logic           root_ge;

   // divider
   logic [SW-1:0]  drem_ff, ddiv_ff;
   logic [S-1:0]   quo_ff;
   logic           div_ge;

   // statistics
   logic [S-1:0]   latest_ff, max_ff, min_ff, peak_x_ff, peak_y_ff, peak_z_ff;
   logic [C-1:0]   count_ff;
   logic [SW-1:0]  total_ff;
   logic           have;

   function automatic logic [S-1:0] abs_of(input logic [S-1:0] raw);
      abs_of = raw[S-1] ? (~raw + 1'b1) : raw;
   endfunction

   assign status.count_zero = (count_ff == '0);
   assign have              = !status.count_zero;

   assign rem_t   = {rem_ff[S-1:0], rad_ff[2*S-1 -: 2]};
   assign trial   = {root_ff, 2'b01};
   assign root_ge = (rem_t >= trial);
   assign div_ge  = (drem_ff >= ddiv_ff);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         abs_x_ff <= abs_of(req_accel_x);
         abs_y_ff <= abs_of(req_accel_y);
         abs_z_ff <= abs_of(req_accel_z);
      end
      if (cmd.square) begin
         sq_x_ff <= abs_x_ff * abs_x_ff;
         sq_y_ff <= abs_y_ff * abs_y_ff;
         sq_z_ff <= abs_z_ff * abs_z_ff;
      end
      // two radicand bits per step, one root bit out
      if (cmd.load_root) begin
         rad_ff  <= sq_x_ff + sq_y_ff + sq_z_ff;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (cmd.root_step) begin
         rad_ff  <= {rad_ff[2*S-3:0], 2'b00};
         rem_ff  <= root_ge ? (rem_t - trial) : rem_t;
         root_ff <= {root_ff[S-2:0], root_ge};
      end
      // quotient fits in S bits, so start with the divisor at bit S-1
      if (cmd.load_div) begin
         drem_ff <= total_ff;
         ddiv_ff <= {{(S - 1){1'b0}}, count_ff, 1'b0} << (S - 2);
         quo_ff  <= '0;
      end else if (cmd.div_step) begin
         drem_ff <= div_ge ? (drem_ff - ddiv_ff) : drem_ff;
         ddiv_ff <= ddiv_ff >> 1;
         quo_ff  <= {quo_ff[S-2:0], div_ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.clear) begin
         latest_ff <= '0;
         count_ff  <= '0;
         total_ff  <= '0;
         max_ff    <= '0;
         min_ff    <= '1;
         peak_x_ff <= '0;
         peak_y_ff <= '0;
         peak_z_ff <= '0;
      end else if (cmd.update) begin
         latest_ff <= root_ff;
         // saturated count freezes both count and total
         if (count_ff != '1) begin
            count_ff <= count_ff + 1'b1;
            total_ff <= total_ff + {{C{1'b0}}, root_ff};
         end
         if (root_ff > max_ff) max_ff <= root_ff;
         if (root_ff < min_ff) min_ff <= root_ff;
         if (abs_x_ff > peak_x_ff) peak_x_ff <= abs_x_ff;
         if (abs_y_ff > peak_y_ff) peak_y_ff <= abs_y_ff;
         if (abs_z_ff > peak_z_ff) peak_z_ff <= abs_z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_rsp) begin
         rsp_current_magnitude <= latest_ff;
         rsp_count_of_samples  <= count_ff;
         rsp_highest_magnitude <= have ? max_ff : '0;
         rsp_lowest_magnitude  <= have ? min_ff : '0;
         rsp_mean_magnitude    <= (have && cmd.summary) ? quo_ff : '0;
         rsp_peak_abs_x        <= peak_x_ff;
         rsp_peak_abs_y        <= peak_y_ff;
         rsp_peak_abs_z        <= peak_z_ff;
         rsp_is_summary        <= cmd.summary;
      end
   end

endmodule

[design/accel_ride_statistics_core.sv]
// ride statistics core: top level joining the controller and the datapath
// depends on ars_pkg, ars_ctrl, ars_datapath
`timescale 1ns / 1ps

// Ride statistics for a three-axis accelerometer. A start transaction
// outside a ride opens a ride and clears the statistics; sample
// transactions inside a ride that are not flagged as taken during vibration
// update the latest magnitude (floor square root of x*x+y*y+z*z), the
// saturating count, the magnitude total, max, min and per-axis absolute
// peaks; a finish transaction closes the ride and returns a summary with
// mean = total / count. Every request transaction yields exactly one
// response transaction. One transaction is in flight at a time. An accepted
// sample runs through the square, sum, digit-serial square root (one root
// bit per cycle), update and commit steps; a finish with counted samples
// runs through the restoring divider (one quotient bit per cycle) and
// commit; any other transaction goes straight to commit. The next request
// can be taken in the cycle after the response is loaded. A response still
// stalled in the output register holds the next one in its commit step
// until it leaves. The response sits in an output register, so the request
// side is free again once the response is loaded, even if the response is
// still stalled.

module accel_ride_statistics_core import ars_pkg::*; #(
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   // request channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_kind,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  logic                          req_during_vibration,
   // response channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [SAMPLE_BITS-1:0]        rsp_current_magnitude,
   output logic [COUNT_BITS-1:0]         rsp_count_of_samples,
   output logic [SAMPLE_BITS-1:0]        rsp_highest_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_lowest_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_mean_magnitude,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_x,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_y,
   output logic [SAMPLE_BITS-1:0]        rsp_peak_abs_z,
   output logic                          rsp_is_summary
);

   // commands from the controller, status back from the datapath
   cmd_type    cmd;
   status_type status;

   // sequencer: ride state, step counter and response valid
   ars_ctrl #(
      .SAMPLE_BITS(SAMPLE_BITS)
   ) u_ctrl (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_kind            (req_kind),
      .req_during_vibration(req_during_vibration),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .status              (status),
      .cmd                 (cmd)
   );

   // arithmetic, statistics and response payload
   ars_datapath #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .status               (status),
      .req_accel_x          (req_accel_x),
      .req_accel_y          (req_accel_y),
      .req_accel_z          (req_accel_z),
      .rsp_current_magnitude(rsp_current_magnitude),
      .rsp_count_of_samples (rsp_count_of_samples),
      .rsp_highest_magnitude(rsp_highest_magnitude),
      .rsp_lowest_magnitude (rsp_lowest_magnitude),
      .rsp_mean_magnitude   (rsp_mean_magnitude),
      .rsp_peak_abs_x       (rsp_peak_abs_x),
      .rsp_peak_abs_y       (rsp_peak_abs_y),
      .rsp_peak_abs_z       (rsp_peak_abs_z),
      .rsp_is_summary       (rsp_is_summary)
   );

   // an accepted request always keeps the block busy for the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request side free right after an accepted transaction");

   // minimum never above maximum in any response
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_lowest_magnitude <= rsp_highest_magnitude)
      else $error("lowest magnitude above highest magnitude");

   // mean only reported on summaries
   a_mean_summary_only: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_is_summary |-> rsp_mean_magnitude == '0)
      else $error("mean reported on a live response");

   // no counted samples means no extremes
   a_empty_ride: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count_of_samples == '0 |->
         rsp_highest_magnitude == '0 && rsp_mean_magnitude == '0)
      else $error("statistics reported with zero samples");

endmodule
